>>> hw/rtl/ccx_pkg.sv
// ----------------------------------------------------------------------------
// ccx_pkg: shared types and constants for the ChaCha20 stream XOR unit
// Register indexes, sigma constants, the quarter round and the front-to-back
// queue entry.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int WordW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  localparam int Rounds = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_INIT_CTR = 3'd6
  } cfg_reg_t;

  localparam logic [WordW-1:0] Sigma0 = 32'h61707865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h79622d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b206574;

  typedef logic [15:0][WordW-1:0] block_t;

  // One queued beat: the word, its byte count, its word index, whether it opens a block, and its block counter.
  typedef struct packed {
    logic [WordW-1:0] data;
    logic [2:0]       nbytes;
    logic [3:0]       widx;
    logic             new_block;
    logic [WordW-1:0] counter;
  } qent_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } qr_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

  function automatic qr_t quarter(input qr_t x);
    qr_t y;
    y = x;
    y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 16);
    y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 12);
    y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 8);
    y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 7);
    quarter = y;
  endfunction

  // One column round followed by one diagonal round.
  function automatic block_t double_round(input block_t s);
    block_t x;
    qr_t q;
    x = s;
    for (int i = 0; i < 4; i++) begin
      q = quarter('{x[i], x[4+i], x[8+i], x[12+i]});
      x[i] = q.a; x[4+i] = q.b; x[8+i] = q.c; x[12+i] = q.d;
    end
    for (int i = 0; i < 4; i++) begin
      q = quarter('{x[i], x[4+((i+1)%4)], x[8+((i+2)%4)], x[12+((i+3)%4)]});
      x[i] = q.a; x[4+((i+1)%4)] = q.b; x[8+((i+2)%4)] = q.c; x[12+((i+3)%4)] = q.d;
    end
    double_round = x;
  endfunction

endpackage

>>> hw/rtl/ccx_if.sv
// ----------------------------------------------------------------------------
// ccx_if: channel interfaces
// Data input, result and configuration write channels.
// ----------------------------------------------------------------------------
interface ccx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        message_start;
  modport source (output valid, data_word, valid_bytes, message_start, input ready);
  modport sink (input valid, data_word, valid_bytes, message_start, output ready);
endinterface

interface ccx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  out_valid_bytes;
  modport source (output valid, out_word, out_valid_bytes, input ready);
  modport sink (input valid, out_word, out_valid_bytes, output ready);
endinterface

interface ccx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/chacha20_stream_xor_unit.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor_unit: IETF ChaCha20 keystream XOR, one word per beat
// Front tags beats with keystream slot and counter, a short queue decouples,
// the back computes blocks and XORs words into a registered output.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   data_word[32], valid_bytes[3], message_start
//  out_ch   out  out_word[32], out_valid_bytes[3]
//  cfg_ch   in   index[3], data[64]
//
//  A word within a block is emitted directly; the first word of each block
//  waits for the core: it starts the core, runs ten double rounds (one per
//  cycle) and then clears the start flag of the queued beat.
//  Words are not emitted while the single double-round unit runs a block.
//  rst is synchronous; it clears word index, counter and all valid flags.
//  Either side may stall; the queue absorbs up to two beats.
module chacha20_stream_xor_unit (
  input  logic  clk,
  input  logic  rst,
  ccx_in_if.sink     in_ch,
  ccx_out_if.source  out_ch,
  ccx_cfg_if.sink    cfg_ch
);
  import ccx_pkg::*;

  logic [63:0] key0, key1, key2, key3, nlo;
  logic [31:0] nhi, ictr;
  block_t cfg_init;
  logic   q_push, q_full, q_pop, q_hv, blk_done_d;
  qent_t  q_in, q_head;
  logic   was_busy;

  // Configuration: always accept, decode index.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0;
      nlo <= '0; nhi <= '0; ictr <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_KEY0: key0 <= cfg_ch.data;
        REG_KEY1: key1 <= cfg_ch.data;
        REG_KEY2: key2 <= cfg_ch.data;
        REG_KEY3: key3 <= cfg_ch.data;
        REG_NONCE_LO: nlo <= cfg_ch.data;
        REG_NONCE_HI: nhi <= cfg_ch.data[31:0];
        REG_INIT_CTR: ictr <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_init[0] = Sigma0; cfg_init[1] = Sigma1;
    cfg_init[2] = Sigma2; cfg_init[3] = Sigma3;
    cfg_init[4] = key0[31:0]; cfg_init[5] = key0[63:32];
    cfg_init[6] = key1[31:0]; cfg_init[7] = key1[63:32];
    cfg_init[8] = key2[31:0]; cfg_init[9] = key2[63:32];
    cfg_init[10] = key3[31:0]; cfg_init[11] = key3[63:32];
    cfg_init[12] = '0;
    cfg_init[13] = nlo[31:0]; cfg_init[14] = nlo[63:32];
    cfg_init[15] = nhi;
  end

  ccx_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .init_ctr(ictr),
    .q_full(q_full), .q_push(q_push), .q_ent(q_in)
  );

  // Detect the block-done edge: back drops busy. Clear head new-block then.
  logic back_busy;
  always_ff @(posedge clk) begin
    if (rst) was_busy <= 1'b0;
    else was_busy <= back_busy;
  end
  assign blk_done_d = was_busy && !back_busy;

  ccx_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_ent(q_in), .full(q_full),
    .pop(q_pop), .clr_head(blk_done_d), .head_valid(q_hv), .head(q_head)
  );

  ccx_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_hv && !blk_done_d), .q_ent(q_head),
    .q_pop(q_pop), .cfg_init(cfg_init), .busy(back_busy), .out_ch(out_ch)
  );
endmodule

>>> hw/rtl/ccx_front.sv
// ----------------------------------------------------------------------------
// ccx_front: input classification
// Tracks word index and block counter, tags each beat with its keystream slot.
// ----------------------------------------------------------------------------
module ccx_front (
  input  logic          clk,
  input  logic          rst,
  ccx_in_if.sink        in_ch,
  input  logic [31:0]   init_ctr,
  input  logic          q_full,
  output logic          q_push,
  output ccx_pkg::qent_t q_ent
);
  import ccx_pkg::*;

  logic [3:0]  widx;
  logic [31:0] ctr;
  logic [3:0]  cur_idx;
  logic [31:0] cur_ctr;

  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && in_ch.ready;
  assign cur_idx = in_ch.message_start ? 4'd0 : widx;
  assign cur_ctr = in_ch.message_start ? init_ctr : ctr;

  always_comb begin
    q_ent.data = in_ch.data_word;
    q_ent.nbytes = (in_ch.valid_bytes == 3'd0 || in_ch.valid_bytes > 3'd4) ? 3'd4
                                                                         : in_ch.valid_bytes;
    q_ent.widx = cur_idx;
    q_ent.new_block = (cur_idx == 4'd0);
    q_ent.counter = cur_ctr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= 4'd0;
      ctr <= '0;
    end else if (q_push) begin
      widx <= cur_idx + 4'd1;
      ctr <= (cur_idx == 4'd0) ? cur_ctr + 32'd1 : cur_ctr;
    end
  end
endmodule

>>> hw/rtl/ccx_back.sv
// ----------------------------------------------------------------------------
// ccx_back: keystream core and XOR
// Runs a block in ten double rounds, then drains words to the output.
// ----------------------------------------------------------------------------
module ccx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ccx_pkg::qent_t q_ent,
  output logic           q_pop,
  input  ccx_pkg::block_t cfg_init,
  output logic           busy,
  ccx_out_if.source      out_ch
);
  import ccx_pkg::*;

  block_t ks;
  block_t st;
  block_t st_next;
  block_t init;
  logic [3:0] rnd;
  logic   ovalid;
  logic [31:0] oword;
  logic [2:0]  onb;
  logic   out_free;
  logic   can_emit;
  logic [31:0] mask;
  block_t start;

  assign out_free = !ovalid || out_ch.ready;
  assign can_emit = q_valid && !busy && out_free && !q_ent.new_block;
  // A new-block beat first starts the core; it pops once the block is done.
  assign q_pop = can_emit;
  assign st_next = double_round(st);

  always_comb begin
    start = cfg_init;
    start[12] = q_ent.counter;
    case (q_ent.nbytes)
      3'd1: mask = 32'h000000ff;
      3'd2: mask = 32'h0000ffff;
      3'd3: mask = 32'h00ffffff;
      default: mask = 32'hffffffff;
    endcase
  end

  logic done_blk;
  assign done_blk = busy && (rnd == 4'(Rounds - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
      ovalid <= 1'b0;
    end else begin
      if (!busy && q_valid && q_ent.new_block) begin
        busy <= 1'b1;
        rnd <= '0;
      end else if (done_blk) begin
        busy <= 1'b0;
      end else if (busy) begin
        rnd <= rnd + 4'd1;
      end
      if (can_emit) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

  // Clearing new_block on the head entry is done in the queue: the top level
  // detects the back dropping busy after a block and clears the head's flag.
  always_ff @(posedge clk) begin
    if (!busy && q_valid && q_ent.new_block) begin
      st <= start;
      init <= start;
    end else if (busy) begin
      st <= st_next;
    end
    if (done_blk) begin
      for (int i = 0; i < 16; i++) ks[i] <= st_next[i] + init[i];
    end
    if (can_emit) begin
      oword <= (q_ent.data ^ ks[q_ent.widx]) & mask;
      onb <= q_ent.nbytes;
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.out_word = oword;
  assign out_ch.out_valid_bytes = onb;
endmodule

>>> hw/rtl/ccx_queue.sv
// ----------------------------------------------------------------------------
// ccx_queue: two-entry queue between front and back
// Holds tagged beats; the back can clear the head's new-block flag.
// ----------------------------------------------------------------------------
module ccx_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccx_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  input  logic           clr_head,
  output logic           head_valid,
  output ccx_pkg::qent_t head
);
  import ccx_pkg::*;

  qent_t ent [QDepth];
  logic [QPtrW-1:0] rp;
  logic [QPtrW-1:0] wp;
  logic [QPtrW:0]   cnt;

  assign full = (cnt == (QPtrW+1)'(QDepth));
  assign head_valid = (cnt != '0);
  assign head = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= push_ent;
    if (clr_head) ent[rp].new_block <= 1'b0;
  end
endmodule
